// File: hw/rtl/srg_pkg.sv
// shared types, constants and arithmetic helpers for the subtractive generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

   localparam int unsigned WORD_W = 30;
   localparam int unsigned MAG_W  = 28;
   localparam int unsigned IDX_W  = 6;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [MAG_W-1:0]  mag_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam word_type MOD_BIG     = 30'd1000000000;
   localparam mag_type  SEED_BASE   = 28'd161803398;
   localparam idx_type  TABLE_LAST  = 6'd54;
   localparam idx_type  SEED_LAST   = 6'd53;
   localparam idx_type  SCATTER_ST  = 6'd20;
   localparam logic [IDX_W:0] SCATTER_STEP = 7'd21;
   localparam logic [IDX_W:0] TABLE_LEN    = 7'd55;
   localparam idx_type  LAG_FWD     = 6'd31;
   localparam idx_type  LAG_BACK    = 6'd24;
   localparam idx_type  RING_WRAP   = 6'd56;
   localparam idx_type  READ_START  = 6'd0;
   localparam idx_type  LAG_START   = 6'd31;
   localparam idx_type  RING_FIRST  = 6'd1;
   localparam logic [1:0] PASS_LAST = 2'd3;

   typedef enum logic [2:0] {
      OP_NOP       = 3'd0,
      OP_LOAD      = 3'd1,
      OP_SEED_INIT = 3'd2,
      OP_SEED_STEP = 3'd3,
      OP_MIX_RD    = 3'd4,
      OP_MIX_WR    = 3'd5,
      OP_DRAW_RD   = 3'd6,
      OP_DRAW_WR   = 3'd7
   } op_type;

   typedef struct packed {
      op_type  op;
      idx_type entry;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   // a - b modulo 10^9, both operands below 10^9
   function automatic word_type sub_mod(input word_type a, input word_type b);
      logic [WORD_W:0] wrapped;
      wrapped = {1'b0, a} + {1'b0, MOD_BIG} - {1'b0, b};
      if (a >= b) begin
         return word_type'(a - b);
      end
      return wrapped[WORD_W-1:0];
   endfunction

   // ring position step, 56 and 0 wrap to 1
   function automatic idx_type ring_next(input idx_type pos);
      idx_type step;
      step = idx_type'(pos + RING_FIRST);
      if (step >= RING_WRAP || step == '0) begin
         return RING_FIRST;
      end
      return step;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srg_req_if.sv
// request channel: draw or reseed beat
// depends on srg_pkg
`timescale 1ns / 1ps
`default_nettype none

interface srg_req_if import srg_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    func;
   mag_type seed_magnitude;

   modport source(output valid, output func, output seed_magnitude, input ready);
   modport sink(input valid, input func, input seed_magnitude, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/srg_rsp_if.sv
// response channel: one random value per beat
// depends on srg_pkg
`timescale 1ns / 1ps
`default_nettype none

interface srg_rsp_if import srg_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type random_value;

   modport source(output valid, output random_value, input ready);
   modport sink(input valid, input random_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/srg_ctrl.sv
// sequencer for seeding, mixing passes and draws
// depends on srg_pkg; drives srg_datapath through cmd_type
`timescale 1ns / 1ps
`default_nettype none

module srg_ctrl import srg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_func,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SEED_INIT = 7'b0000010,
      ST_SEED_STEP = 7'b0000100,
      ST_MIX_RD    = 7'b0001000,
      ST_MIX_WR    = 7'b0010000,
      ST_DRAW_RD   = 7'b0100000,
      ST_DRAW_WR   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   idx_type    cnt_ff, cnt_in;
   logic [1:0] pass_ff, pass_in;
   logic       seeded_ff, seeded_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pass_in   = pass_ff;
      seeded_in = seeded_ff;
      cmd.op    = OP_NOP;
      cmd.entry = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (req_func || !seeded_ff) begin
                  state_in = ST_SEED_INIT;
               end else begin
                  state_in = ST_DRAW_RD;
               end
            end
         end
         ST_SEED_INIT: begin
            cmd.op    = OP_SEED_INIT;
            cnt_in    = '0;
            seeded_in = 1'b1;
            state_in  = ST_SEED_STEP;
         end
         ST_SEED_STEP: begin
            cmd.op = OP_SEED_STEP;
            if (cnt_ff == SEED_LAST) begin
               cnt_in   = '0;
               pass_in  = '0;
               state_in = ST_MIX_RD;
            end else begin
               cnt_in = idx_type'(cnt_ff + RING_FIRST);
            end
         end
         ST_MIX_RD: begin
            cmd.op   = OP_MIX_RD;
            state_in = ST_MIX_WR;
         end
         ST_MIX_WR: begin
            cmd.op = OP_MIX_WR;
            if (cnt_ff == TABLE_LAST) begin
               cnt_in = '0;
               if (pass_ff == PASS_LAST) begin
                  state_in = ST_DRAW_RD;
               end else begin
                  pass_in  = pass_ff + 2'd1;
                  state_in = ST_MIX_RD;
               end
            end else begin
               cnt_in   = idx_type'(cnt_ff + RING_FIRST);
               state_in = ST_MIX_RD;
            end
         end
         ST_DRAW_RD: begin
            cmd.op   = OP_DRAW_RD;
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            if (!status.out_busy) begin
               cmd.op   = OP_DRAW_WR;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         pass_ff   <= '0;
         seeded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         pass_ff   <= pass_in;
         seeded_ff <= seeded_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/srg_datapath.sv
// lag table memory, seeding recurrence, ring indices and output register
// depends on srg_pkg; commanded by srg_ctrl
`timescale 1ns / 1ps
`default_nettype none

module srg_datapath import srg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  mag_type    req_seed_magnitude,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output word_type   rsp_random_value
);

   word_type table_mem [0:54];

   mag_type  mag_ff, mag_in;
   word_type cur_ff, cur_in;
   word_type prev_ff, prev_in;
   idx_type  pos_ff, pos_in;
   idx_type  read_pos_ff, read_pos_in;
   idx_type  lag_pos_ff, lag_pos_in;
   word_type rd_a_ff, rd_b_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_value_ff, rsp_value_in;

   logic           wr_en, rd_en;
   idx_type        wr_addr, rd_a_addr, rd_b_addr;
   word_type       wr_data, diff, seed_value;
   mag_type        seed_abs;
   idx_type        lag_entry, read_next, lag_next;
   logic [IDX_W:0] scatter_sum;

   assign diff       = sub_mod(rd_a_ff, rd_b_ff);
   assign seed_abs   = (mag_ff <= SEED_BASE) ? mag_type'(SEED_BASE - mag_ff)
                                             : mag_type'(mag_ff - SEED_BASE);
   assign seed_value = word_type'(seed_abs);
   assign lag_entry  = (cmd.entry < LAG_BACK) ? idx_type'(cmd.entry + LAG_FWD)
                                              : idx_type'(cmd.entry - LAG_BACK);
   assign read_next  = ring_next(read_pos_ff);
   assign lag_next   = ring_next(lag_pos_ff);
   assign scatter_sum = {1'b0, pos_ff} + SCATTER_STEP;

   assign status.out_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   always_comb begin
      mag_in       = mag_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      pos_in       = pos_ff;
      read_pos_in  = read_pos_ff;
      lag_pos_in   = lag_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      wr_en        = 1'b0;
      wr_addr      = cmd.entry;
      wr_data      = diff;
      rd_en        = 1'b0;
      rd_a_addr    = cmd.entry;
      rd_b_addr    = lag_entry;
      case (cmd.op)
         OP_LOAD: begin
            mag_in = req_seed_magnitude;
         end
         OP_SEED_INIT: begin
            wr_en       = 1'b1;
            wr_addr     = TABLE_LAST;
            wr_data     = seed_value;
            cur_in      = seed_value;
            prev_in     = word_type'(1);
            pos_in      = SCATTER_ST;
            read_pos_in = READ_START;
            lag_pos_in  = LAG_START;
         end
         OP_SEED_STEP: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = prev_ff;
            prev_in = sub_mod(cur_ff, prev_ff);
            cur_in  = prev_ff;
            if (scatter_sum >= TABLE_LEN) begin
               pos_in = idx_type'(scatter_sum - TABLE_LEN);
            end else begin
               pos_in = scatter_sum[IDX_W-1:0];
            end
         end
         OP_MIX_RD: begin
            rd_en = 1'b1;
         end
         OP_MIX_WR: begin
            wr_en = 1'b1;
         end
         OP_DRAW_RD: begin
            rd_en       = 1'b1;
            read_pos_in = read_next;
            lag_pos_in  = lag_next;
            rd_a_addr   = idx_type'(read_next - RING_FIRST);
            rd_b_addr   = idx_type'(lag_next - RING_FIRST);
         end
         OP_DRAW_WR: begin
            wr_en        = 1'b1;
            wr_addr      = idx_type'(read_pos_ff - RING_FIRST);
            rsp_valid_in = 1'b1;
            rsp_value_in = diff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= table_mem[rd_a_addr];
         rd_b_ff <= table_mem[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      pos_ff       <= pos_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_pos_ff  <= READ_START;
         lag_pos_ff   <= LAG_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         read_pos_ff  <= read_pos_in;
         lag_pos_ff   <= lag_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/subtractive_random_generator.sv
// draw: one request at a time, taken in idle, then a read and a write step on
// the single 55-entry lag table memory; a stalled response holds the write step
// reseed (func=1, or first draw after reset) first adds 1 init write,
// 54 scatter writes and 4 mixing passes of 55 entries, a read and write step each
// synchronous reset clears the sequencer, ring indices and response valid;
// the table is rebuilt on the first draw
`timescale 1ns / 1ps
`default_nettype none

module subtractive_random_generator import srg_pkg::*; (
   input  logic clock,
   input  logic reset,
   srg_req_if.sink   req_chan,
   srg_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   srg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   srg_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_seed_magnitude (req_chan.seed_magnitude),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_random_value   (rsp_chan.random_value)
   );

endmodule

`default_nettype wire

// File: hw/rtl/srg_checker.sv
// port-level checks for subtractive_random_generator, attached by bind
// depends on srg_pkg
`timescale 1ns / 1ps
`default_nettype none

module srg_checker import srg_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input word_type rsp_random_value
);

   // values stay below 10^9
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_random_value < MOD_BIG))
      else $error("random value out of range");

   // stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_random_value)))
      else $error("stalled response changed");

   // one request in flight: busy right after a request beat
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // no response straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind subtractive_random_generator srg_checker u_srg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_random_value (rsp_chan.random_value)
);

`default_nettype wire
